FILE: src/afw_pkg.sv
// Shared constants, codes and types of the affine warp bilinear sampler.
`timescale 1ns / 1ps

package afw_pkg;

  // Default image store dimensions.
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned NumCoef   = 6;

  // Field widths.
  localparam int unsigned FuncW   = 2;
  localparam int unsigned PosW    = 8;
  localparam int unsigned PixW    = 16;
  localparam int unsigned CidxW   = 3;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FracW   = 16;

  // Normalizing divider: numerator is pos * 2^18 + d, divisor is 2 * d.
  localparam int unsigned NumW = PosW + 18;
  localparam int unsigned DenW = CfgW + 1;

  // Datapath widths of the coordinate transform.
  localparam int unsigned OxW   = NumW + 1;
  localparam int unsigned ProdW = CoefW + OxW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned TW    = SumW - FracW + 1;

  typedef enum logic [FuncW-1:0] {
    FUNC_PIXEL  = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IN_WIDTH   = 2'd0,
    CFG_IN_HEIGHT  = 2'd1,
    CFG_OUT_WIDTH  = 2'd2,
    CFG_OUT_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic [PosW-1:0]         row;
    logic [PosW-1:0]         col;
    logic signed [PixW-1:0]  pixel;
    logic [CidxW-1:0]        cidx;
    logic signed [CoefW-1:0] cval;
  } item_t;

endpackage

FILE: src/affine_warp_bilinear_sampler_top.sv
// Top level of the affine warp bilinear sampler: pipeline, coefficient and image store.
`timescale 1ns / 1ps

// The block warps one image channel by a 2x3 affine matrix in signed Q8.16 and samples
// the source bilinearly. Every transaction on the input channel is a pixel load, a
// coefficient load or a sample request; only samples return a transaction on the output
// channel, in the order they were taken. The block takes one transaction per cycle and
// delivers one result per cycle. A sample passes through the pipelined divider that
// normalizes the output position, three multiply stages for the matrix and the scale
// to source pixels, the image store read and the blend, rounding and saturation.
// The image store is split into four banks by the parity of row and column, so the four
// neighbors of a sample always fall in four different banks and are read in the same
// cycle. Loads travel the same pipeline as samples and write the coefficients and the
// store at the stage where samples read them, so every sample sees exactly the loads
// that preceded it. Pixels that were never loaded read as undefined values. The whole
// pipeline holds only while a finished result waits on a stalled output; an input
// transaction is then stalled too. Configuration writes are always ready and must only
// be issued while the block is idle.
module affine_warp_bilinear_sampler_top #(
  parameter int unsigned MaxWidth  = afw_pkg::MaxWidth,
  parameter int unsigned MaxHeight = afw_pkg::MaxHeight
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [afw_pkg::FuncW-1:0]           func_i,
  input  logic [afw_pkg::PosW-1:0]            row_i,
  input  logic [afw_pkg::PosW-1:0]            col_i,
  input  logic signed [afw_pkg::PixW-1:0]     pixel_value_i,
  input  logic [afw_pkg::CidxW-1:0]           coef_index_i,
  input  logic signed [afw_pkg::CoefW-1:0]    coef_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [afw_pkg::PixW-1:0]     sample_value_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [afw_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [afw_pkg::CfgW-1:0]            cfg_data_i
);

  localparam int unsigned NW    = afw_pkg::NumW;
  localparam int unsigned FracW = afw_pkg::FracW;
  localparam int unsigned CfgW  = afw_pkg::CfgW;
  localparam int unsigned PixW  = afw_pkg::PixW;
  localparam int unsigned CoefW = afw_pkg::CoefW;
  localparam int unsigned OxW   = afw_pkg::OxW;
  localparam int unsigned ProdW = afw_pkg::ProdW;
  localparam int unsigned SumW  = afw_pkg::SumW;
  localparam int unsigned TW    = afw_pkg::TW;

  // Geometry of the banked image store.
  localparam int unsigned XW        = $clog2(MaxWidth);
  localparam int unsigned YW        = $clog2(MaxHeight);
  localparam int unsigned HalfW     = (MaxWidth + 1) / 2;
  localparam int unsigned HalfH     = (MaxHeight + 1) / 2;
  localparam int unsigned BankDepth = HalfW * HalfH;
  localparam int unsigned BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;

  // Source size after saturation, and the scale factors size - 1.
  localparam int unsigned DimXW = $clog2(MaxWidth + 1);
  localparam int unsigned DimYW = $clog2(MaxHeight + 1);
  localparam int unsigned ScxW  = XW;
  localparam int unsigned ScyW  = YW;
  localparam int unsigned PxW   = TW + ScxW + 1;
  localparam int unsigned PyW   = TW + ScyW + 1;
  localparam int unsigned CxW   = PxW - FracW;
  localparam int unsigned CyW   = PyW - FracW;

  // Blend widths.
  localparam int unsigned WgtW = 2 * FracW + 1;
  localparam int unsigned PpW  = WgtW + 1 + PixW;
  localparam int unsigned AccW = PpW + 2;
  localparam int unsigned RndW = AccW - 2 * FracW;
  localparam logic signed [AccW-1:0] RoundBias = AccW'(64'd1 << (2 * FracW - 1));

  // ------------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------------
  logic [CfgW-1:0] in_width_q, in_width_d;
  logic [CfgW-1:0] in_height_q, in_height_d;
  logic [CfgW-1:0] out_width_q, out_width_d;
  logic [CfgW-1:0] out_height_q, out_height_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_width_d   = in_width_q;
    in_height_d  = in_height_q;
    out_width_d  = out_width_q;
    out_height_d = out_height_q;
    if (cfg_valid_i) begin
      case (afw_pkg::cfg_idx_e'(cfg_index_i))
        afw_pkg::CFG_IN_WIDTH:   in_width_d   = cfg_data_i;
        afw_pkg::CFG_IN_HEIGHT:  in_height_d  = cfg_data_i;
        afw_pkg::CFG_OUT_WIDTH:  out_width_d  = cfg_data_i;
        afw_pkg::CFG_OUT_HEIGHT: out_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q   <= CfgW'(256);
      in_height_q  <= CfgW'(256);
      out_width_q  <= CfgW'(256);
      out_height_q <= CfgW'(256);
    end else begin
      in_width_q   <= in_width_d;
      in_height_q  <= in_height_d;
      out_width_q  <= out_width_d;
      out_height_q <= out_height_d;
    end
  end

  // Derived sizes. The user must change them only while the pipeline is empty; the block does not enforce this.
  logic [DimXW-1:0] iw;
  logic [DimYW-1:0] ih;
  logic [ScxW-1:0]  scx;
  logic [ScyW-1:0]  scy;
  logic [CfgW-1:0]  dx, dy;
  logic             dgx, dgy;

  assign iw  = (32'(in_width_q) > MaxWidth) ? DimXW'(MaxWidth) : DimXW'(in_width_q);
  assign ih  = (32'(in_height_q) > MaxHeight) ? DimYW'(MaxHeight) : DimYW'(in_height_q);
  assign scx = (iw == '0) ? '0 : ScxW'(iw - DimXW'(1));
  assign scy = (ih == '0) ? '0 : ScyW'(ih - DimYW'(1));
  assign dx  = out_width_q - CfgW'(1);
  assign dy  = out_height_q - CfgW'(1);
  // An output size of zero or one puts every position at the center.
  assign dgx = (out_width_q <= CfgW'(1));
  assign dgy = (out_height_q <= CfgW'(1));

  // ------------------------------------------------------------------------
  // Flow control. Every stage moves together; the pipeline holds only when a
  // result sits in the output register and the consumer stalls it.
  // ------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ------------------------------------------------------------------------
  // Normalization: ox = floor((col * 2^18 + d) / (2 * d)) - 2^16.
  // ------------------------------------------------------------------------
  logic [NW-1:0]              quo_x, quo_y;
  logic                       dv_valid_q [NW];
  afw_pkg::item_t             dv_item_q  [NW];
  afw_pkg::item_t             in_item;

  assign in_item = '{func:  func_i,
                     row:   row_i,
                     col:   col_i,
                     pixel: pixel_value_i,
                     cidx:  coef_index_i,
                     cval:  coef_value_i};

  afw_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({col_i, 18'(dx)}),
    .den_i ({dx, 1'b0}),
    .quo_o (quo_x)
  );

  afw_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({row_i, 18'(dy)}),
    .den_i ({dy, 1'b0}),
    .quo_o (quo_y)
  );

  // The item travels alongside the divider stages.
  for (genvar s = 0; s < NW; s++) begin : g_dv
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_valid_q[s] <= 1'b0;
        end else if (en) begin
          dv_valid_q[s] <= in_valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_item_q[s] <= in_item;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dv_valid_q[s] <= 1'b0;
        end else if (en) begin
          dv_valid_q[s] <= dv_valid_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_item_q[s] <= dv_item_q[s-1];
        end
      end
    end
  end

  logic                  dv_valid;
  afw_pkg::item_t        dv_item;
  logic signed [OxW-1:0] ox, oy;

  assign dv_valid = dv_valid_q[NW-1];
  assign dv_item  = dv_item_q[NW-1];
  assign ox = dgx ? '0 : OxW'($signed({1'b0, quo_x}) - (1 <<< FracW));
  assign oy = dgy ? '0 : OxW'($signed({1'b0, quo_y}) - (1 <<< FracW));

  // ------------------------------------------------------------------------
  // Coefficients. A coefficient load writes at the stage where samples read
  // them, so the order of loads and samples is kept.
  // ------------------------------------------------------------------------
  logic signed [CoefW-1:0] coef_q [afw_pkg::NumCoef];
  logic                    coef_we;

  assign coef_we = en && dv_valid && (dv_item.func == afw_pkg::FUNC_COEF) &&
                   (32'(dv_item.cidx) < afw_pkg::NumCoef);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < afw_pkg::NumCoef; i++) begin
        coef_q[i] <= '0;
      end
    end else if (coef_we) begin
      coef_q[dv_item.cidx] <= dv_item.cval;
    end
  end

  // Stage 1: the four matrix products.
  logic                      s1_valid_q;
  afw_pkg::item_t            s1_item_q;
  logic signed [ProdW-1:0]   mxa_q, mxb_q, mya_q, myb_q;
  logic signed [CoefW-1:0]   offx_q, offy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q <= dv_item;
      mxa_q     <= ProdW'(coef_q[0] * ox);
      mxb_q     <= ProdW'(coef_q[1] * oy);
      mya_q     <= ProdW'(coef_q[3] * ox);
      myb_q     <= ProdW'(coef_q[4] * oy);
      offx_q    <= coef_q[2];
      offy_q    <= coef_q[5];
    end
  end

  // Stage 2: sum in Q.32, floor to Q.16, and shift the range to start at zero.
  logic signed [SumW-1:0] sum_x, sum_y;
  logic signed [TW-1:0]   t_x_d, t_y_d;
  logic signed [TW-1:0]   t_x_q, t_y_q;
  logic                   s2_valid_q;
  afw_pkg::item_t         s2_item_q;

  assign sum_x = SumW'(mxa_q) + SumW'(mxb_q) + (SumW'(offx_q) <<< FracW);
  assign sum_y = SumW'(mya_q) + SumW'(myb_q) + (SumW'(offy_q) <<< FracW);
  assign t_x_d = TW'(sum_x >>> FracW) + TW'(1 << FracW);
  assign t_y_d = TW'(sum_y >>> FracW) + TW'(1 << FracW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_item_q <= s1_item_q;
      t_x_q     <= t_x_d;
      t_y_q     <= t_y_d;
    end
  end

  // Stage 3: scale to source pixels. Source x in Q.16 is this product halved.
  logic signed [PxW-1:0] pr_x_q;
  logic signed [PyW-1:0] pr_y_q;
  logic                  s3_valid_q;
  afw_pkg::item_t        s3_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_item_q <= s2_item_q;
      pr_x_q    <= PxW'(t_x_q * $signed({1'b0, scx}));
      pr_y_q    <= PyW'(t_y_q * $signed({1'b0, scy}));
    end
  end

  // ------------------------------------------------------------------------
  // Image store access. The integer part is a floor because the shift is
  // arithmetic. Bank b holds pixels whose column parity is b[0] and whose
  // row parity is b[1]; each neighbor lands in exactly one bank.
  // ------------------------------------------------------------------------
  logic signed [CxW-1:0] xi;
  logic signed [CyW-1:0] yi;
  logic [FracW-1:0]      fx, fy;
  logic [FracW:0]        wx0, wy0;

  assign xi  = CxW'(pr_x_q >>> (FracW + 1));
  assign yi  = CyW'(pr_y_q >>> (FracW + 1));
  assign fx  = pr_x_q[FracW:1];
  assign fy  = pr_y_q[FracW:1];
  assign wx0 = (FracW + 1)'(1 << FracW) - {1'b0, fx};
  assign wy0 = (FracW + 1)'(1 << FracW) - {1'b0, fy};

  logic [BankAw-1:0] rd_addr  [4];
  logic              rd_ok    [4];
  logic [WgtW-1:0]   wgt_d    [4];
  logic [BankAw-1:0] wr_addr;
  logic              wr_ok;
  logic [3:0]        bank_we;
  logic [PixW-1:0]   rd_data  [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic           sx_b, sy_b;
    logic [CxW-1:0] xb;
    logic [CyW-1:0] yb;
    logic [FracW:0] wxb, wyb;

    assign sx_b = xi[0] ^ b[0];
    assign sy_b = yi[0] ^ b[1];
    assign xb   = xi + CxW'(sx_b);
    assign yb   = yi + CyW'(sy_b);
    assign rd_ok[b] = !xb[CxW-1] && (xb < CxW'(iw)) && !yb[CyW-1] && (yb < CyW'(ih));
    assign rd_addr[b] = BankAw'(32'(yb[YW-1:0] >> 1) * HalfW + 32'(xb[XW-1:0] >> 1));
    assign wxb = sx_b ? {1'b0, fx} : wx0;
    assign wyb = sy_b ? {1'b0, fy} : wy0;
    assign wgt_d[b] = WgtW'(wxb * wyb);
    assign bank_we[b] = wr_ok && (s3_item_q.col[0] == b[0]) && (s3_item_q.row[0] == b[1]);

    afw_ram #(
      .Width (PixW),
      .Depth (BankDepth)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (wr_addr),
      .wdata_i (s3_item_q.pixel),
      .re_i    (en),
      .raddr_i (rd_addr[b]),
      .rdata_o (rd_data[b])
    );
  end

  // Pixel loads write here, in the same stage where samples read.
  assign wr_ok = en && s3_valid_q && (s3_item_q.func == afw_pkg::FUNC_PIXEL) &&
                 (32'(s3_item_q.row) < MaxHeight) && (32'(s3_item_q.col) < MaxWidth);
  assign wr_addr = BankAw'(32'(s3_item_q.row >> 1) * HalfW + 32'(s3_item_q.col >> 1));

  // Stage 4: weights and inside flags line up with the store read data.
  logic            s4_smp_q;
  logic [WgtW-1:0] wgt_q [4];
  logic            ok_q  [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_smp_q <= 1'b0;
    end else if (en) begin
      s4_smp_q <= s3_valid_q && (s3_item_q.func == afw_pkg::FUNC_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int b = 0; b < 4; b++) begin
        wgt_q[b] <= wgt_d[b];
        ok_q[b]  <= rd_ok[b];
      end
    end
  end

  // Stage 5: weight times pixel; a neighbor outside the source counts as zero.
  logic                  s5_smp_q;
  logic signed [PpW-1:0] pp_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_smp_q <= 1'b0;
    end else if (en) begin
      s5_smp_q <= s4_smp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int b = 0; b < 4; b++) begin
        pp_q[b] <= ok_q[b] ? PpW'($signed({1'b0, wgt_q[b]}) * $signed(rd_data[b])) : '0;
      end
    end
  end

  // Output stage: sum in Q.32, round half up, saturate.
  logic signed [AccW-1:0] acc;
  logic signed [RndW-1:0] rnd;
  logic signed [PixW-1:0] sat;
  logic signed [PixW-1:0] sample_q;

  assign acc = AccW'(pp_q[0]) + AccW'(pp_q[1]) + AccW'(pp_q[2]) + AccW'(pp_q[3]) + RoundBias;
  assign rnd = RndW'(acc >>> (2 * FracW));

  always_comb begin
    if (rnd > RndW'(32767)) begin
      sat = PixW'(32767);
    end else if (rnd < RndW'(-32768)) begin
      sat = PixW'(-32768);
    end else begin
      sat = PixW'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s5_smp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sample_q <= sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_q;

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------
  // A pixel load writes at most one bank.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(bank_we))
    else $error("more than one image bank written in a cycle");

  // While the pipeline holds, the sample markers of the blend stages keep their values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !en |=> $stable(s4_smp_q) && $stable(s5_smp_q))
    else $error("blend stages moved while the pipeline was held");

  // The input is stalled only on behalf of a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // Coefficients change only through a coefficient load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !coef_we |=> $stable(coef_q[0]) && $stable(coef_q[1]) &&
                   $stable(coef_q[2]) && $stable(coef_q[3]) &&
                   $stable(coef_q[4]) && $stable(coef_q[5]))
    else $error("coefficient changed without a load");

endmodule

FILE: src/afw_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module afw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/afw_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module afw_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [afw_pkg::NumW-1:0]  num_i,
  input  logic [afw_pkg::DenW-1:0]  den_i,
  output logic [afw_pkg::NumW-1:0]  quo_o
);

  localparam int unsigned NW = afw_pkg::NumW;
  localparam int unsigned DW = afw_pkg::DenW;

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
    end

    // The partial remainder stays below the divisor, so it fits DW bits.
    assign trial = {rem_in, num_in[NW-1-s]};
    assign ge    = (trial >= {1'b0, den_in});
    assign rem_d = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= {quo_in[NW-2:0], ge};
        num_q[s] <= num_in;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule
